/* src/lfupr_pkg.sv */
// shared types and constants for the lfu page replacement block
package lfupr_pkg;

  localparam int unsigned CFG_W       = 5;
  localparam int unsigned PAGE_NUM_W  = 16;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned COUNT_OUT_W = 16;
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned TIME_W      = 32;

  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } lfupr_state_e;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic scan_en;
    logic commit;
  } lfupr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } lfupr_sts_t;

endpackage

/* src/lfupr_if.sv */
// request, result and configuration channel interfaces
interface lfupr_req_if
  import lfupr_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [PAGE_NUM_W-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

interface lfupr_rsp_if
  import lfupr_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic [SLOT_W-1:0]      frame_slot;
  logic                   evicted_valid;
  logic [PAGE_NUM_W-1:0]  evicted_page;
  logic [COUNT_OUT_W-1:0] use_count_now;
  logic [TOTAL_W-1:0]     total_hits;
  logic [TOTAL_W-1:0]     total_faults;

  modport source (output valid, output hit, output frame_slot, output evicted_valid,
                  output evicted_page, output use_count_now, output total_hits,
                  output total_faults, input ready);
  modport sink   (input valid, input hit, input frame_slot, input evicted_valid,
                  input evicted_page, input use_count_now, input total_hits,
                  input total_faults, output ready);
endinterface

interface lfupr_cfg_if
  import lfupr_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] frames_in_use;

  modport source (output valid, output frames_in_use, input ready);
  modport sink   (input valid, input frames_in_use, output ready);
endinterface

/* src/lfupr_ctrl.sv */
// sequencing state machine: accept, scan frames, commit result
module lfupr_ctrl
  import lfupr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  lfupr_sts_t sts_i,
  output lfupr_cmd_t cmd_o
);

  lfupr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.scan_done) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o   = 1'b0;
    cmd_o.start   = 1'b0;
    cmd_o.scan_en = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.start = req_valid_i;
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
      end
      ST_COMMIT: begin
        cmd_o.commit = sts_i.out_free;
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

endmodule

/* src/lfupr_dp.sv */
// frame memory, scan/compare pipeline, counters and result register
module lfupr_dp
  import lfupr_pkg::*;
#(
  parameter int unsigned FRAME_COUNT = 16,
  parameter int unsigned PAGE_BITS   = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lfupr_cmd_t             cmd_i,
  output lfupr_sts_t             sts_o,
  input  logic [PAGE_NUM_W-1:0]  page_number_i,
  input  logic                   cfg_valid_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  logic                   rsp_ready_i,
  output logic                   rsp_valid_o,
  output logic                   hit_o,
  output logic [SLOT_W-1:0]      frame_slot_o,
  output logic                   evicted_valid_o,
  output logic [PAGE_NUM_W-1:0]  evicted_page_o,
  output logic [COUNT_OUT_W-1:0] use_count_now_o,
  output logic [TOTAL_W-1:0]     total_hits_o,
  output logic [TOTAL_W-1:0]     total_faults_o
);

  localparam int unsigned IDX_W  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int unsigned FILL_W = $clog2(FRAME_COUNT + 1);
  localparam int unsigned CAP_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;
  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(FRAME_COUNT);
  localparam logic [CAP_W-1:0] CAP_MIN = CAP_W'(1);

  typedef struct packed {
    logic [PAGE_BITS-1:0]  tag;
    logic [COUNT_BITS-1:0] cnt;
    logic [TIME_W-1:0]     last_use;
  } entry_t;

  entry_t mem [FRAME_COUNT];

  // control state
  logic [CFG_W-1:0]   frames_in_use_q;
  logic [FILL_W-1:0]  filled_q;
  logic [FILL_W-1:0]  issue_idx_q;
  logic               rd_v_q;
  logic               found_q;
  logic               best_v_q;
  logic               rsp_valid_q;
  logic [TIME_W-1:0]  clock_q;
  logic [TOTAL_W-1:0] hit_total_q;
  logic [TOTAL_W-1:0] fault_total_q;

  // payload
  entry_t                 rdata_q;
  logic [IDX_W-1:0]       rd_idx_q;
  logic [PAGE_BITS-1:0]   page_q;
  logic [IDX_W-1:0]       hit_idx_q;
  logic [COUNT_BITS-1:0]  hit_cnt_q;
  logic [IDX_W-1:0]       best_idx_q;
  logic [PAGE_BITS-1:0]   best_tag_q;
  logic [COUNT_BITS-1:0]  best_cnt_q;
  logic [TIME_W-1:0]      best_time_q;
  logic                   hit_q;
  logic [SLOT_W-1:0]      slot_q;
  logic                   ev_v_q;
  logic [PAGE_NUM_W-1:0]  ev_page_q;
  logic [COUNT_OUT_W-1:0] cnt_out_q;

  logic                      issuing;
  logic                      match;
  logic                      better;
  logic [PAGE_BITS+15:0]     page_wide;
  logic [PAGE_BITS-1:0]      page_in;
  logic [CAP_W-1:0]          fiu_ext;
  logic [CAP_W-1:0]          cap;
  logic                      fill;
  logic [IDX_W-1:0]          slot_idx;
  logic [COUNT_BITS-1:0]     hit_cnt_inc;
  logic [COUNT_BITS-1:0]     new_cnt;
  entry_t                    wentry;
  logic [IDX_W+SLOT_W-1:0]   slot_wide;
  logic [PAGE_BITS+15:0]     ev_wide;
  logic [COUNT_BITS+15:0]    cnt_wide;

  assign page_wide = {{PAGE_BITS{1'b0}}, page_number_i};
  assign page_in   = page_wide[PAGE_BITS-1:0];

  assign issuing = cmd_i.scan_en && (issue_idx_q < filled_q);
  assign match   = rd_v_q && (rdata_q.tag == page_q);
  assign better  = !best_v_q || (rdata_q.cnt < best_cnt_q) ||
                   ((rdata_q.cnt == best_cnt_q) && (rdata_q.last_use < best_time_q));

  // capacity clamped into 1..FRAME_COUNT
  always_comb begin
    fiu_ext = CAP_W'(frames_in_use_q);
    priority if (fiu_ext == '0) begin
      cap = CAP_MIN;
    end else if (fiu_ext > CAP_MAX) begin
      cap = CAP_MAX;
    end else begin
      cap = fiu_ext;
    end
  end

  assign fill        = !found_q && (CAP_W'(filled_q) < cap);
  assign hit_cnt_inc = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + 1'b1;
  assign new_cnt     = found_q ? hit_cnt_inc : COUNT_BITS'(1);

  always_comb begin
    priority if (found_q) begin
      slot_idx = hit_idx_q;
    end else if (fill) begin
      slot_idx = filled_q[IDX_W-1:0];
    end else begin
      slot_idx = best_idx_q;
    end
  end

  assign wentry.tag      = page_q;
  assign wentry.cnt      = new_cnt;
  assign wentry.last_use = clock_q;

  assign slot_wide = {{SLOT_W{1'b0}}, slot_idx};
  assign ev_wide   = {{16{1'b0}}, best_tag_q};
  assign cnt_wide  = {{16{1'b0}}, new_cnt};

  // frame memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) mem[slot_idx] <= wentry;
    if (issuing) rdata_q <= mem[issue_idx_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= FRAMES_IN_USE_RESET;
      filled_q        <= '0;
      issue_idx_q     <= '0;
      rd_v_q          <= 1'b0;
      found_q         <= 1'b0;
      best_v_q        <= 1'b0;
      rsp_valid_q     <= 1'b0;
      clock_q         <= '0;
      hit_total_q     <= '0;
      fault_total_q   <= '0;
    end else begin
      if (cfg_valid_i) frames_in_use_q <= cfg_data_i;
      rd_v_q <= issuing;
      if (cmd_i.start) begin
        issue_idx_q <= '0;
        found_q     <= 1'b0;
        best_v_q    <= 1'b0;
      end else begin
        if (issuing) issue_idx_q <= issue_idx_q + 1'b1;
        if (match) found_q <= 1'b1;
        if (rd_v_q) best_v_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        rsp_valid_q <= 1'b1;
        if (fill) filled_q <= filled_q + 1'b1;
        if (clock_q != '1) clock_q <= clock_q + 1'b1;
        if (found_q) begin
          if (hit_total_q != '1) hit_total_q <= hit_total_q + 1'b1;
        end else begin
          if (fault_total_q != '1) fault_total_q <= fault_total_q + 1'b1;
        end
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= issue_idx_q[IDX_W-1:0];
    if (cmd_i.start) page_q <= page_in;
    if (match && !found_q) begin
      hit_idx_q <= rd_idx_q;
      hit_cnt_q <= rdata_q.cnt;
    end
    if (rd_v_q && better) begin
      best_idx_q  <= rd_idx_q;
      best_tag_q  <= rdata_q.tag;
      best_cnt_q  <= rdata_q.cnt;
      best_time_q <= rdata_q.last_use;
    end
    if (cmd_i.commit) begin
      hit_q     <= found_q;
      slot_q    <= slot_wide[SLOT_W-1:0];
      ev_v_q    <= !found_q && !fill;
      ev_page_q <= (!found_q && !fill) ? ev_wide[PAGE_NUM_W-1:0] : '0;
      cnt_out_q <= cnt_wide[COUNT_OUT_W-1:0];
    end
  end

  assign sts_o.scan_done = (issue_idx_q == filled_q) && !rd_v_q;
  assign sts_o.out_free  = !rsp_valid_q || rsp_ready_i;

  assign rsp_valid_o     = rsp_valid_q;
  assign hit_o           = hit_q;
  assign frame_slot_o    = slot_q;
  assign evicted_valid_o = ev_v_q;
  assign evicted_page_o  = ev_page_q;
  assign use_count_now_o = cnt_out_q;
  assign total_hits_o    = hit_total_q;
  assign total_faults_o  = fault_total_q;

endmodule

/* src/lfu_page_replacement_top.sv */
// an accepted request scans the filled frames, then commits its result once the output is free;
// the next request is not taken before that commit, and the scan reads one entry per cycle
//   through the single read port of the frame memory
// a new request is taken while the previous result still waits in the output register
// reset (async, active low) empties all frames, clears the time and totals and sets
//   the frame limit to 16; no clearing pass, frame contents are never read before written
module lfu_page_replacement_top
  import lfupr_pkg::*;
#(
  parameter int unsigned FRAME_COUNT = 16,
  parameter int unsigned PAGE_BITS   = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lfupr_req_if.sink   req_i,
  lfupr_rsp_if.source rsp_o,
  lfupr_cfg_if.sink   cfg_i
);

  // command and status bundles between the sequencer and the datapath
  lfupr_cmd_t cmd;
  lfupr_sts_t sts;
  logic       req_ready;

  // frame limit register is always writable; writes must arrive only while idle, the block does not enforce it
  assign cfg_i.ready = 1'b1;
  assign req_i.ready = req_ready;

  // sequencer: idle -> scan every filled frame -> commit when the output is free
  lfupr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: frame memory, hit search and lfu/lru victim search in one pass,
  // saturating counters, output register
  lfupr_dp #(
    .FRAME_COUNT (FRAME_COUNT),
    .PAGE_BITS   (PAGE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .page_number_i   (req_i.page_number),
    .cfg_valid_i     (cfg_i.valid),
    .cfg_data_i      (cfg_i.frames_in_use),
    .rsp_ready_i     (rsp_o.ready),
    .rsp_valid_o     (rsp_o.valid),
    .hit_o           (rsp_o.hit),
    .frame_slot_o    (rsp_o.frame_slot),
    .evicted_valid_o (rsp_o.evicted_valid),
    .evicted_page_o  (rsp_o.evicted_page),
    .use_count_now_o (rsp_o.use_count_now),
    .total_hits_o    (rsp_o.total_hits),
    .total_faults_o  (rsp_o.total_faults)
  );

endmodule

/* src/lfupr_checker.sv */
// port-level assertions for the lfu page replacement top, with bind
module lfupr_checker
  import lfupr_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   rsp_valid_i,
  input logic                   rsp_ready_i,
  input logic                   hit_i,
  input logic [SLOT_W-1:0]      frame_slot_i,
  input logic                   evicted_valid_i,
  input logic [PAGE_NUM_W-1:0]  evicted_page_i,
  input logic [COUNT_OUT_W-1:0] use_count_now_i,
  input logic [TOTAL_W-1:0]     total_hits_i,
  input logic [TOTAL_W-1:0]     total_faults_i
);

  // a hit never evicts, and a result without an eviction reports page zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(hit_i && evicted_valid_i) && (evicted_valid_i || evicted_page_i == '0))
    else $error("eviction fields inconsistent with hit");

  // a fault always loads the page with a use count of one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !hit_i |-> use_count_now_i == COUNT_OUT_W'(1))
    else $error("fault result with use count other than one");

  // the running total for this kind of request already includes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (hit_i ? total_hits_i != '0 : total_faults_i != '0))
    else $error("running total misses the current request");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(hit_i) && $stable(frame_slot_i)
      && $stable(evicted_page_i) && $stable(use_count_now_i) && $stable(total_hits_i))
    else $error("result changed while stalled");

endmodule

bind lfu_page_replacement_top lfupr_checker u_lfupr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .hit_i           (rsp_o.hit),
  .frame_slot_i    (rsp_o.frame_slot),
  .evicted_valid_i (rsp_o.evicted_valid),
  .evicted_page_i  (rsp_o.evicted_page),
  .use_count_now_i (rsp_o.use_count_now),
  .total_hits_i    (rsp_o.total_hits),
  .total_faults_i  (rsp_o.total_faults)
);

/* sim/lfu_page_replacement_top_test.sv */
// self-checking testbench for the lfu page replacement block with lru tie-break
`timescale 1ns / 1ps

module lfu_page_replacement_top_test;
  import lfupr_pkg::*;

  localparam int unsigned FRAMES      = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_CYCLES = 40;    // a margin over the worst request-to-result latency

  // one result as it leaves the block
  typedef struct packed {
    logic                   hit;
    logic [SLOT_W-1:0]      frame_slot;
    logic                   evicted_valid;
    logic [PAGE_NUM_W-1:0]  evicted_page;
    logic [COUNT_OUT_W-1:0] use_count_now;
    logic [TOTAL_W-1:0]     total_hits;
    logic [TOTAL_W-1:0]     total_faults;
  } page_outcome_t;

  // frame table mirror: predicts each outcome when a request is taken,
  // compares results against the oldest prediction
  class lfu_frame_scoreboard;
    bit [PAGE_NUM_W-1:0]  tags[FRAMES];
    bit [COUNT_OUT_W-1:0] counts[FRAMES];
    bit [TIME_W-1:0]      last_use[FRAMES];
    int unsigned          filled;
    bit [TIME_W-1:0]      ref_clock;
    bit [TOTAL_W-1:0]     hit_count;
    bit [TOTAL_W-1:0]     fault_count;
    bit [CFG_W-1:0]       frame_limit;
    page_outcome_t        expected_outcomes[$];
    int unsigned          mismatches;

    function new();
      filled      = 0;
      ref_clock   = '0;
      hit_count   = '0;
      fault_count = '0;
      frame_limit = FRAMES_IN_USE_RESET;
      mismatches  = 0;
    endfunction

    function void set_frame_limit(bit [CFG_W-1:0] limit);
      frame_limit = limit;
    endfunction

    function void note_reference(bit [PAGE_NUM_W-1:0] page);
      page_outcome_t o;
      int unsigned   cap;
      int unsigned   slot;
      bit            found;
      o     = '0;
      found = 1'b0;
      slot  = 0;
      for (int i = 0; i < filled; i++) begin
        if (!found && tags[i] == page) begin
          found = 1'b1;
          slot  = i;
        end
      end
      // zero acts as one frame, anything past the table as the whole table
      cap = (frame_limit == 0) ? 1 : ((frame_limit > FRAMES) ? FRAMES : frame_limit);
      if (found) begin
        if (counts[slot] != '1) counts[slot]++;
        last_use[slot]  = ref_clock;
        o.hit           = 1'b1;
        o.use_count_now = counts[slot];
        if (hit_count != '1) hit_count++;
      end else begin
        if (fault_count != '1) fault_count++;
        if (filled < cap) begin
          slot = filled;
          filled++;
        end else begin
          // lowest count wins, then oldest use, then lowest index
          slot = 0;
          for (int i = 1; i < filled; i++) begin
            if (counts[i] < counts[slot] ||
                (counts[i] == counts[slot] && last_use[i] < last_use[slot]))
              slot = i;
          end
          o.evicted_valid = 1'b1;
          o.evicted_page  = tags[slot];
        end
        tags[slot]      = page;
        counts[slot]    = COUNT_OUT_W'(1);
        last_use[slot]  = ref_clock;
        o.use_count_now = COUNT_OUT_W'(1);
      end
      if (ref_clock != '1) ref_clock++;
      o.frame_slot   = slot[SLOT_W-1:0];
      o.total_hits   = hit_count;
      o.total_faults = fault_count;
      expected_outcomes = {expected_outcomes, o};
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_outcome(page_outcome_t got);
      page_outcome_t want;
      if (expected_outcomes.size() == 0) begin
        $error("result with no request outstanding: frame_slot %0d", got.frame_slot);
        mismatches++;
        return;
      end
      want = expected_outcomes.pop_front();
      compare_field("hit", want.hit, got.hit);
      compare_field("frame_slot", want.frame_slot, got.frame_slot);
      compare_field("evicted_valid", want.evicted_valid, got.evicted_valid);
      compare_field("evicted_page", want.evicted_page, got.evicted_page);
      compare_field("use_count_now", want.use_count_now, got.use_count_now);
      compare_field("total_hits", want.total_hits, got.total_hits);
      compare_field("total_faults", want.total_faults, got.total_faults);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  lfupr_req_if req_if ();
  lfupr_rsp_if rsp_if ();
  lfupr_cfg_if cfg_if ();

  lfu_frame_scoreboard sb = new();

  // per-item idle limits, switched between 0 and 17 per phase
  int unsigned request_gap_max  = 0;
  int unsigned result_stall_max = 0;
  int unsigned cycle_count      = 0;

  lfu_page_replacement_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  always #1 clk = ~clk;

  // one request per call; valid stays high on a zero gap so back-to-back
  // requests never see valid dropped and raised in the same step
  task automatic send_reference(input bit [PAGE_NUM_W-1:0] page);
    int unsigned gap;
    req_if.valid       <= 1'b1;
    req_if.page_number <= page;
    do @(posedge clk); while (!req_if.ready);
    gap = $urandom_range(0, request_gap_max);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop requesting and hold off until every predicted result came back;
  // the first edge lets the monitor log a request taken at this very edge
  task automatic wait_for_outcomes();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_outcomes.size() != 0) @(posedge clk);
  endtask

  // frame limit write, only issued once the block is idle
  task automatic write_frame_limit(input bit [CFG_W-1:0] limit);
    cfg_if.valid         <= 1'b1;
    cfg_if.frames_in_use <= limit;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // result side backpressure: a fresh stall drawn for every result
  initial begin
    int unsigned stall;
    forever begin
      stall = $urandom_range(0, result_stall_max);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
    end
  end

  // monitor: config writes, requests and results in edge order within one process
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) sb.set_frame_limit(cfg_if.frames_in_use);
      if (req_if.valid && req_if.ready) sb.note_reference(req_if.page_number);
      if (rsp_if.valid && rsp_if.ready)
        sb.check_outcome({rsp_if.hit, rsp_if.frame_slot, rsp_if.evicted_valid,
                          rsp_if.evicted_page, rsp_if.use_count_now,
                          rsp_if.total_hits, rsp_if.total_faults});
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("lfu_page_replacement_top test failed");
    $finish;
  end

  initial begin
    int unsigned    sent;
    int unsigned    burst;
    int unsigned    pool_n;
    int unsigned    pick;
    int unsigned    alt;
    int unsigned    mode;
    bit [PAGE_NUM_W-1:0] pool[40];

    rst_n                <= 1'b0;
    req_if.valid         <= 1'b0;
    req_if.page_number   <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.frames_in_use <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, with idling on both sides
    request_gap_max  = 17;
    result_stall_max = 17;

    // reset limit of 16: page extremes, then repeat hits to build counts
    send_reference(16'h0000);
    send_reference(16'hFFFF);
    send_reference(16'h0000);
    send_reference(16'hFFFF);
    send_reference(16'hFFFF);

    // two frames, both full: misses evict the least used frame
    wait_for_outcomes();
    write_frame_limit(5'd2);
    send_reference(16'h1234);
    send_reference(16'h1234);
    send_reference(16'h4321);

    // zero behaves as one frame, already below the filled count;
    // the last miss hits a count tie that the older use decides
    wait_for_outcomes();
    write_frame_limit(5'd0);
    send_reference(16'h8001);
    send_reference(16'h8001);
    send_reference(16'h8001);
    send_reference(16'h7FFE);

    // oversized limit clamps to the table size, filling resumes
    wait_for_outcomes();
    write_frame_limit(5'd31);
    for (int i = 0; i < 10; i++) send_reference(PAGE_NUM_W'(16'h0100 + i));

    // limit of one with a dozen filled: misses evict among all of them
    wait_for_outcomes();
    write_frame_limit(5'd1);
    send_reference(16'hA5A5);
    send_reference(16'h5A5A);

    // random part: skewed draws from a per-phase working set so that
    // counts spread and hits, fills and evictions all show up
    sent = 0;
    while (sent < 630) begin
      wait_for_outcomes();
      mode             = $urandom_range(0, 3);
      request_gap_max  = mode[0] ? 17 : 0;
      result_stall_max = mode[1] ? 17 : 0;
      case ($urandom_range(0, 5))
        0:       write_frame_limit(5'd0);
        1:       write_frame_limit(5'd1);
        2:       write_frame_limit(5'd16);
        3:       write_frame_limit(5'd31);
        default: write_frame_limit(CFG_W'($urandom_range(0, 31)));
      endcase
      pool_n = $urandom_range(2, 40);
      foreach (pool[i]) pool[i] = PAGE_NUM_W'($urandom_range(0, 65535));
      burst = $urandom_range(30, 70);
      for (int k = 0; k < burst; k++) begin
        // once, in the middle of the first phase, drain fully before going on
        if (sent == 0 && k == burst / 2) wait_for_outcomes();
        if ($urandom_range(0, 3) == 0) begin
          send_reference(PAGE_NUM_W'($urandom_range(0, 65535)));
        end else begin
          pick = $urandom_range(0, pool_n - 1);
          alt  = $urandom_range(0, pool_n - 1);
          if (alt < pick) pick = alt;
          send_reference(pool[pick]);
        end
      end
      sent += burst;
    end

    wait_for_outcomes();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_outcomes.size() == 0) begin
      $display("lfu_page_replacement_top test passed");
    end else begin
      $display("lfu_page_replacement_top test failed");
    end
    $finish;
  end

endmodule
